[rtl/core/ront_pkg.sv]
package ront_pkg;

	localparam int TABLE_DEPTH = 16;
	localparam int PROTECTED   = 4;
	localparam int ID_BITS     = 32;

	localparam int FIELD_W  = 32;
	localparam int STATUS_W = 3;
	localparam int COUNT_W  = 5;
	localparam int IN_W     = ((2 * FIELD_W + 7) / 8) * 8;
	localparam int OUT_W    = ((5 * FIELD_W + COUNT_W + 7) / 8) * 8;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_LOOKUP = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		STS_OWN       = 3'd0,
		STS_REFRESHED = 3'd1,
		STS_INSERTED  = 3'd2,
		STS_EVICTED   = 3'd3,
		STS_LOOKUP    = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		SW_SCAN   = 2'd0,
		SW_REMOVE = 2'd1,
		SW_SHIFT  = 2'd2
	} sweep_t;

	typedef struct packed {
		logic   take;
		logic   sweep_start;
		sweep_t sweep_kind;
		logic   sweep_run;
		logic   refresh;
		logic   put;
		logic   cnt_dec;
		logic   mark_evict;
		logic   rd_head;
		logic   rd_tail;
		logic   load_out;
	} ront_cmd_t;

	typedef struct packed {
		logic is_lookup;
		logic key_own;
		logic found;
		logic full;
		logic sweep_done;
	} ront_stat_t;

endpackage

[rtl/core/ront_ram.sv]
module ront_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[rtl/core/ront_ctrl.sv]
module ront_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	input  ront_pkg::ront_stat_t st,
	output ront_pkg::ront_cmd_t  cmd
);

	typedef enum logic [9:0] {
		ST_IDLE    = 10'b0000000001,
		ST_START   = 10'b0000000010,
		ST_SCAN    = 10'b0000000100,
		ST_REMOVE  = 10'b0000001000,
		ST_SHIFT   = 10'b0000010000,
		ST_PUT     = 10'b0000100000,
		ST_REFRESH = 10'b0001000000,
		ST_HEAD    = 10'b0010000000,
		ST_TAIL    = 10'b0100000000,
		ST_RESULT  = 10'b1000000000
	} state_t;

	state_t state_q, state_d;
	logic   m_tvalid_q;

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.take = 1'b1;
					state_d  = ST_START;
				end
			end
			ST_START: begin
				if (!st.is_lookup && st.key_own) begin
					state_d = ST_HEAD;
				end else begin
					cmd.sweep_start = 1'b1;
					cmd.sweep_kind  = ront_pkg::SW_SCAN;
					state_d         = ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.sweep_run = 1'b1;
				if (st.sweep_done) begin
					priority if (st.is_lookup) begin
						state_d = ST_HEAD;
					end else if (st.found) begin
						state_d = ST_REFRESH;
					end else if (st.full) begin
						cmd.mark_evict  = 1'b1;
						cmd.sweep_start = 1'b1;
						cmd.sweep_kind  = ront_pkg::SW_REMOVE;
						state_d         = ST_REMOVE;
					end else begin
						cmd.sweep_start = 1'b1;
						cmd.sweep_kind  = ront_pkg::SW_SHIFT;
						state_d         = ST_SHIFT;
					end
				end
			end
			ST_REMOVE: begin
				cmd.sweep_run = 1'b1;
				if (st.sweep_done) begin
					// table shrank by one; locate the new key again
					cmd.cnt_dec     = 1'b1;
					cmd.sweep_start = 1'b1;
					cmd.sweep_kind  = ront_pkg::SW_SCAN;
					state_d         = ST_SCAN;
				end
			end
			ST_SHIFT: begin
				cmd.sweep_run = 1'b1;
				if (st.sweep_done) begin
					state_d = ST_PUT;
				end
			end
			ST_PUT: begin
				cmd.put = 1'b1;
				state_d = ST_HEAD;
			end
			ST_REFRESH: begin
				cmd.refresh = 1'b1;
				state_d     = ST_HEAD;
			end
			ST_HEAD: begin
				cmd.rd_head = 1'b1;
				state_d     = ST_TAIL;
			end
			ST_TAIL: begin
				cmd.rd_tail = 1'b1;
				state_d     = ST_RESULT;
			end
			ST_RESULT: begin
				if (!m_tvalid_q || m_tready) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

endmodule

[rtl/core/ront_dpath.sv]
module ront_dpath #(
	parameter int TABLE_DEPTH = ront_pkg::TABLE_DEPTH,
	parameter int PROTECTED   = ront_pkg::PROTECTED,
	parameter int ID_BITS     = ront_pkg::ID_BITS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [ront_pkg::FIELD_W-1:0] cfg_wdata,
	input  logic                        s_tuser,
	input  logic [ront_pkg::IN_W-1:0]   s_tdata,
	output logic [ront_pkg::OUT_W-1:0]  m_tdata,
	output logic [ront_pkg::STATUS_W-1:0] m_tuser,
	input  ront_pkg::ront_cmd_t         cmd,
	output ront_pkg::ront_stat_t        st
);

	localparam int FW    = ront_pkg::FIELD_W;
	localparam int ID_W  = (ID_BITS < FW) ? ID_BITS : FW;
	localparam int AW    = $clog2(TABLE_DEPTH);
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam int EVICT_START = (PROTECTED - 1 < TABLE_DEPTH - 1) ?
	                             (PROTECTED - 1) : (TABLE_DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(TABLE_DEPTH);
	localparam logic [AW-1:0]    EVICT_IDX = AW'(EVICT_START);
	localparam int PAD_W = ront_pkg::OUT_W - 5 * FW - ront_pkg::COUNT_W;

	// x lies strictly inside the clockwise arc (a, b); a == b covers the whole ring
	function automatic logic ring_between(input logic [ID_W-1:0] x,
	                                      input logic [ID_W-1:0] a,
	                                      input logic [ID_W-1:0] b);
		logic [ID_BITS-1:0] dx;
		logic [ID_BITS-1:0] db;
		dx = ID_BITS'(x) - ID_BITS'(a);
		db = ID_BITS'(b) - ID_BITS'(a);
		return (a == b) || ((dx != '0) && (dx < db));
	endfunction

	logic [ID_W-1:0]  own_q;
	logic             op_q;
	logic [ID_W-1:0]  key_q;
	logic [FW-1:0]    now_q;
	logic [CNT_W-1:0] count_q;

	ront_pkg::sweep_t kind_q;
	logic [CNT_W-1:0] a_q;
	logic             rv_s1;
	logic [AW-1:0]    ridx_s1;

	logic             found_q;
	logic [AW-1:0]    found_idx_q;
	logic             lru_v_q;
	logic [FW-1:0]    lru_time_q;
	logic [AW-1:0]    lru_idx_q;
	logic [ID_W-1:0]  lru_id_q;
	logic             hit_v_q;
	logic [AW-1:0]    pos_q;
	logic [ID_W-1:0]  pred_q;
	logic [ID_W-1:0]  succ_q;
	logic [ID_W-1:0]  prev_q;
	logic             evict_q;
	logic [ID_W-1:0]  evicted_id_q;
	logic [ID_W-1:0]  first_q;

	logic [ront_pkg::OUT_W-1:0]    out_tdata_q;
	logic [ront_pkg::STATUS_W-1:0] out_tuser_q;

	logic             ram_re;
	logic [AW-1:0]    ram_raddr;
	logic [ID_W-1:0]  rd_id;
	logic [FW-1:0]    rd_time;
	logic             id_we;
	logic             time_we;
	logic [AW-1:0]    ram_waddr;
	logic [ID_W-1:0]  wr_id;
	logic [FW-1:0]    wr_time;

	logic             issue_ok;
	logic             issue;
	logic [CNT_W-1:0] a_dec;
	logic [CNT_W-1:0] cnt_dec;
	logic [CNT_W-1:0] pos_w;
	logic [AW-1:0]    sweep_addr;
	logic             key_own;
	logic             scan_hit;
	ront_pkg::status_t sts;
	logic [ID_W-1:0]  pred_out;
	logic [ID_W-1:0]  succ_out;
	logic [ID_W-1:0]  evict_out;
	logic [ID_W-1:0]  first_out;
	logic [ID_W-1:0]  final_out;

	assign key_own = (key_q == own_q);
	assign a_dec   = a_q - CNT_W'(1);
	assign cnt_dec = count_q - CNT_W'(1);
	assign pos_w   = hit_v_q ? CNT_W'(pos_q) : count_q;

	// shift sweep walks down from the tail, the others walk up from a start index
	always_comb begin
		if (kind_q == ront_pkg::SW_SHIFT) begin
			issue_ok   = (a_q > pos_w);
			sweep_addr = a_dec[AW-1:0];
		end else begin
			issue_ok   = (a_q < count_q);
			sweep_addr = a_q[AW-1:0];
		end
	end

	assign issue = cmd.sweep_run && issue_ok;

	always_comb begin
		ram_re = issue || cmd.rd_head || cmd.rd_tail;
		priority if (cmd.rd_head) begin
			ram_raddr = '0;
		end else if (cmd.rd_tail) begin
			ram_raddr = cnt_dec[AW-1:0];
		end else begin
			ram_raddr = sweep_addr;
		end
	end

	always_comb begin
		id_we     = 1'b0;
		time_we   = 1'b0;
		ram_waddr = ridx_s1;
		wr_id     = rd_id;
		wr_time   = rd_time;
		priority if (rv_s1 && kind_q == ront_pkg::SW_REMOVE) begin
			id_we     = 1'b1;
			time_we   = 1'b1;
			ram_waddr = ridx_s1 - AW'(1);
		end else if (rv_s1 && kind_q == ront_pkg::SW_SHIFT) begin
			id_we     = 1'b1;
			time_we   = 1'b1;
			ram_waddr = ridx_s1 + AW'(1);
		end else if (cmd.put) begin
			id_we     = 1'b1;
			time_we   = 1'b1;
			ram_waddr = pos_w[AW-1:0];
			wr_id     = key_q;
			wr_time   = now_q;
		end else if (cmd.refresh) begin
			time_we   = 1'b1;
			ram_waddr = found_idx_q;
			wr_time   = now_q;
		end
	end

	ront_ram #(
		.WIDTH(ID_W),
		.DEPTH(TABLE_DEPTH)
	) u_id_ram (
		.clk  (clk),
		.we   (id_we),
		.waddr(ram_waddr),
		.wdata(wr_id),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(rd_id)
	);

	ront_ram #(
		.WIDTH(FW),
		.DEPTH(TABLE_DEPTH)
	) u_time_ram (
		.clk  (clk),
		.we   (time_we),
		.waddr(ram_waddr),
		.wdata(wr_time),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(rd_time)
	);

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_q   <= '0;
			count_q <= '0;
			kind_q  <= ront_pkg::SW_SCAN;
			a_q     <= '0;
			rv_s1   <= 1'b0;
			found_q <= 1'b0;
			lru_v_q <= 1'b0;
			hit_v_q <= 1'b0;
			evict_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				own_q <= cfg_wdata[ID_W-1:0];
			end
			if (cmd.put) begin
				count_q <= count_q + CNT_W'(1);
			end else if (cmd.cnt_dec) begin
				count_q <= cnt_dec;
			end
			if (cmd.sweep_start) begin
				kind_q <= cmd.sweep_kind;
				rv_s1  <= 1'b0;
				unique case (cmd.sweep_kind)
					ront_pkg::SW_REMOVE: a_q <= CNT_W'(lru_idx_q) + CNT_W'(1);
					ront_pkg::SW_SHIFT:  a_q <= count_q;
					default:             a_q <= '0;
				endcase
			end else begin
				rv_s1 <= issue;
				if (issue) begin
					a_q <= (kind_q == ront_pkg::SW_SHIFT) ? a_dec : a_q + CNT_W'(1);
				end
			end
			if (cmd.sweep_start && cmd.sweep_kind == ront_pkg::SW_SCAN) begin
				found_q <= 1'b0;
				lru_v_q <= 1'b0;
				hit_v_q <= 1'b0;
			end else if (rv_s1 && kind_q == ront_pkg::SW_SCAN) begin
				if (!found_q && rd_id == key_q) begin
					found_q <= 1'b1;
				end
				if (ridx_s1 >= EVICT_IDX && (!lru_v_q || rd_time < lru_time_q)) begin
					lru_v_q <= 1'b1;
				end
				if (!hit_v_q && scan_hit) begin
					hit_v_q <= 1'b1;
				end
			end
			if (cmd.take) begin
				evict_q <= 1'b0;
			end else if (cmd.mark_evict) begin
				evict_q <= 1'b1;
			end
		end
	end

	assign scan_hit = ring_between(key_q, prev_q, rd_id) || (rd_id == key_q);

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			op_q  <= s_tuser;
			key_q <= s_tdata[ID_W-1:0];
			now_q <= s_tdata[2*FW-1:FW];
		end
		if (issue) begin
			ridx_s1 <= ram_raddr;
		end
		if (cmd.sweep_start && cmd.sweep_kind == ront_pkg::SW_SCAN) begin
			prev_q <= own_q;
		end else if (rv_s1 && kind_q == ront_pkg::SW_SCAN) begin
			prev_q <= rd_id;
			if (!found_q && rd_id == key_q) begin
				found_idx_q <= ridx_s1;
			end
			if (ridx_s1 >= EVICT_IDX && (!lru_v_q || rd_time < lru_time_q)) begin
				lru_time_q <= rd_time;
				lru_idx_q  <= ridx_s1;
				lru_id_q   <= rd_id;
			end
			if (!hit_v_q && scan_hit) begin
				pos_q  <= ridx_s1;
				pred_q <= prev_q;
				succ_q <= rd_id;
			end
		end
		if (cmd.mark_evict) begin
			evicted_id_q <= lru_id_q;
		end
		if (cmd.rd_tail) begin
			first_q <= rd_id;
		end
		if (cmd.load_out) begin
			out_tuser_q <= sts;
			out_tdata_q <= {{PAD_W{1'b0}},
			                ront_pkg::COUNT_W'(count_q),
			                FW'(final_out),
			                FW'(first_out),
			                FW'(evict_out),
			                FW'(succ_out),
			                FW'(pred_out)};
		end
	end

	always_comb begin
		priority if (op_q == ront_pkg::OP_LOOKUP) begin
			sts = ront_pkg::STS_LOOKUP;
		end else if (key_own) begin
			sts = ront_pkg::STS_OWN;
		end else if (found_q) begin
			sts = ront_pkg::STS_REFRESHED;
		end else if (evict_q) begin
			sts = ront_pkg::STS_EVICTED;
		end else begin
			sts = ront_pkg::STS_INSERTED;
		end
	end

	// no hit in the scan: key falls between the tail and the own id
	always_comb begin
		if (op_q == ront_pkg::OP_LOOKUP) begin
			pred_out = hit_v_q ? pred_q : prev_q;
			succ_out = hit_v_q ? succ_q : own_q;
		end else begin
			pred_out = '0;
			succ_out = '0;
		end
		evict_out = (sts == ront_pkg::STS_EVICTED) ? evicted_id_q : '0;
		// rd_id still holds the tail read
		first_out = (count_q != '0) ? first_q : own_q;
		final_out = (count_q != '0) ? rd_id : own_q;
	end

	assign m_tdata = out_tdata_q;
	assign m_tuser = out_tuser_q;

	assign st.is_lookup  = (op_q == ront_pkg::OP_LOOKUP);
	assign st.key_own    = key_own;
	assign st.found      = found_q;
	assign st.full       = (count_q == FULL_CNT);
	assign st.sweep_done = !issue_ok && !rv_s1;

endmodule

[rtl/core/ring_ordered_neighbor_table_core.sv]
// Ring neighbor table: holds up to TABLE_DEPTH ids in clockwise order from own_id, each
// with a last-used tick, in a pair of single-port-read RAMs walked by a sweep counter
// one entry per cycle. A lookup or a refresh scans the entries; a plain insert scans,
// then shifts the entries behind the new slot; an insert that evicts the least recently
// used unprotected entry scans, closes the gap, scans again and shifts. An own-id insert
// does no scan. Items are handled one at a time; a finished result sits in the output
// register while the next transaction is accepted and worked on.
module ring_ordered_neighbor_table_core #(
	parameter int TABLE_DEPTH = ront_pkg::TABLE_DEPTH,
	parameter int PROTECTED   = ront_pkg::PROTECTED,
	parameter int ID_BITS     = ront_pkg::ID_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [ront_pkg::FIELD_W-1:0]  cfg_wdata,   // own_id
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [ront_pkg::IN_W-1:0]     s_tdata,     // key, now
	input  logic                          s_tuser,     // opcode
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// pred_id, succ_id, evicted_id, first_id, final_id, entry_count
	output logic [ront_pkg::OUT_W-1:0]    m_tdata,
	output logic [ront_pkg::STATUS_W-1:0] m_tuser      // status
);

	ront_pkg::ront_cmd_t  cmd;
	ront_pkg::ront_stat_t st;

	ront_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.st      (st),
		.cmd     (cmd)
	);

	ront_dpath #(
		.TABLE_DEPTH(TABLE_DEPTH),
		.PROTECTED  (PROTECTED),
		.ID_BITS    (ID_BITS)
	) u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_tuser  (s_tuser),
		.s_tdata  (s_tdata),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cmd      (cmd),
		.st       (st)
	);

`ifndef SYNTHESIS
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("input accepted while a transaction is in flight");

	a_out_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!m_tvalid || m_tready))
		else $error("result register overwritten before it was taken");

	a_put_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.put |-> !st.full)
		else $error("entry placed into a full table");

	a_single_action: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.take, cmd.refresh, cmd.put, cmd.rd_head, cmd.rd_tail, cmd.load_out}))
		else $error("conflicting datapath commands");
`endif

endmodule

[verif/ront_checker.sv]
module ront_checker
	import ront_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [FIELD_W-1:0]   cfg_wdata,
	input  logic                 s_tvalid,
	input  logic                 s_tready,
	input  logic [IN_W-1:0]      s_tdata,
	input  logic                 s_tuser,
	input  logic                 m_tvalid,
	input  logic                 m_tready,
	input  logic [OUT_W-1:0]     m_tdata,
	input  logic [STATUS_W-1:0]  m_tuser,
	output int                   fail_count,
	output int                   pending
);

	typedef struct {
		status_t              status;
		logic [FIELD_W-1:0]   pred_id;
		logic [FIELD_W-1:0]   succ_id;
		logic [FIELD_W-1:0]   evicted_id;
		logic [FIELD_W-1:0]   first_id;
		logic [FIELD_W-1:0]   last_id;
		logic [COUNT_W-1:0]   entry_count;
	} nbr_result_t;

	// shadow copy of the neighbor table
	logic [FIELD_W-1:0] node_id;
	logic [FIELD_W-1:0] nbr_ids [TABLE_DEPTH];
	logic [FIELD_W-1:0] nbr_times [TABLE_DEPTH];
	int                 nbr_count;

	nbr_result_t        expected_results [$];
	int                 errors;

	assign fail_count = errors;

	// clockwise open interval (a, b); a == b covers the whole ring
	function automatic logic on_arc(logic [FIELD_W-1:0] x, logic [FIELD_W-1:0] a,
			logic [FIELD_W-1:0] b);
		logic [FIELD_W-1:0] dx;
		logic [FIELD_W-1:0] db;
		dx = x - a;
		db = b - a;
		if (a == b)
			return 1'b1;
		return (dx != '0) && (dx < db);
	endfunction

	function automatic nbr_result_t apply_table_op(logic op, logic [FIELD_W-1:0] key,
			logic [FIELD_W-1:0] now);
		nbr_result_t r;
		logic        found;
		int          i;
		int          best;
		int          pos;
		r.status     = STS_LOOKUP;
		r.pred_id    = '0;
		r.succ_id    = '0;
		r.evicted_id = '0;
		found        = 1'b0;
		if (op == OP_INSERT) begin
			if (key == node_id) begin
				r.status = STS_OWN;
			end else begin
				for (i = 0; i < nbr_count; i++) begin
					if (!found && nbr_ids[i] == key) begin
						nbr_times[i] = now;
						found = 1'b1;
					end
				end
				if (found) begin
					r.status = STS_REFRESHED;
				end else begin
					r.status = STS_INSERTED;
					if (nbr_count >= TABLE_DEPTH) begin
						// LRU victim among unprotected slots, tail included, first on ties
						best = PROTECTED - 1;
						if (best >= nbr_count)
							best = nbr_count - 1;
						for (i = best + 1; i < nbr_count; i++)
							if (nbr_times[i] < nbr_times[best])
								best = i;
						r.evicted_id = nbr_ids[best];
						for (i = best; i + 1 < nbr_count; i++) begin
							nbr_ids[i]   = nbr_ids[i + 1];
							nbr_times[i] = nbr_times[i + 1];
						end
						nbr_count--;
						r.status = STS_EVICTED;
					end
					pos = nbr_count;
					if (nbr_count == 0 || on_arc(key, node_id, nbr_ids[0])) begin
						pos = 0;
					end else begin
						for (i = nbr_count - 2; i >= 0; i--)
							if (on_arc(key, nbr_ids[i], nbr_ids[i + 1]))
								pos = i + 1;
					end
					for (i = nbr_count; i > pos; i--) begin
						nbr_ids[i]   = nbr_ids[i - 1];
						nbr_times[i] = nbr_times[i - 1];
					end
					nbr_ids[pos]   = key;
					nbr_times[pos] = now;
					nbr_count++;
				end
			end
		end else begin
			if (nbr_count == 0) begin
				r.pred_id = node_id;
				r.succ_id = node_id;
			end else if (on_arc(key, node_id, nbr_ids[0]) || nbr_ids[0] == key) begin
				r.pred_id = node_id;
				r.succ_id = nbr_ids[0];
			end else begin
				found = 1'b0;
				for (i = 0; i < nbr_count; i++) begin
					if (!found) begin
						r.pred_id = nbr_ids[i];
						if (i + 1 >= nbr_count) begin
							r.succ_id = node_id;
							found = 1'b1;
						end else if (on_arc(key, nbr_ids[i], nbr_ids[i + 1]) ||
								nbr_ids[i + 1] == key) begin
							r.succ_id = nbr_ids[i + 1];
							found = 1'b1;
						end
					end
				end
			end
		end
		r.first_id    = (nbr_count != 0) ? nbr_ids[0] : node_id;
		r.last_id     = (nbr_count != 0) ? nbr_ids[nbr_count - 1] : node_id;
		r.entry_count = nbr_count[COUNT_W-1:0];
		return r;
	endfunction

	task automatic check_field(string name, logic [FIELD_W-1:0] exp_v,
			logic [FIELD_W-1:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s mismatch: expected %0h, got %0h", name, exp_v, act_v);
			errors++;
		end
	endtask

	initial begin
		errors    = 0;
		nbr_count = 0;
		node_id   = '0;
		pending   = 0;
	end

	always @(posedge clk) begin
		nbr_result_t e;
		if (!arst_n) begin
			node_id   = '0;
			nbr_count = 0;
			expected_results.delete();
		end else begin
			if (cfg_we)
				node_id = cfg_wdata;
			// results first: one accepted on this edge belongs to an earlier item
			if (m_tvalid && m_tready) begin
				if (expected_results.size() == 0) begin
					$error("result transaction with no outstanding item");
					errors++;
				end else begin
					e = expected_results.pop_front();
					check_field("status", FIELD_W'(e.status), FIELD_W'(m_tuser));
					check_field("pred_id", e.pred_id, m_tdata[0 +: FIELD_W]);
					check_field("succ_id", e.succ_id, m_tdata[FIELD_W +: FIELD_W]);
					check_field("evicted_id", e.evicted_id, m_tdata[2*FIELD_W +: FIELD_W]);
					check_field("first_id", e.first_id, m_tdata[3*FIELD_W +: FIELD_W]);
					check_field("final_id", e.last_id, m_tdata[4*FIELD_W +: FIELD_W]);
					check_field("entry_count", FIELD_W'(e.entry_count),
						FIELD_W'(m_tdata[5*FIELD_W +: COUNT_W]));
				end
			end
			if (s_tvalid && s_tready)
				expected_results.push_back(apply_table_op(s_tuser,
					s_tdata[0 +: FIELD_W], s_tdata[FIELD_W +: FIELD_W]));
		end
		pending <= expected_results.size();
	end

endmodule

[verif/tb.sv]
module tb;
	import ront_pkg::*;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                cfg_we;
	logic [FIELD_W-1:0]  cfg_wdata;
	logic                s_tvalid;
	logic                s_tready;
	logic [IN_W-1:0]     s_tdata;     // key, now
	logic                s_tuser;     // opcode
	logic                m_tvalid;
	logic                m_tready;
	logic [OUT_W-1:0]    m_tdata;     // pred_id, succ_id, evicted_id, first_id, final_id, entry_count
	logic [STATUS_W-1:0] m_tuser;     // status

	int                  fail_count;
	int                  pending;

	int                  tx_gap_max;
	int                  rx_stall_max;
	logic                long_hold;

	logic [FIELD_W-1:0]  node_id;
	logic [FIELD_W-1:0]  tick;
	logic [FIELD_W-1:0]  recent_keys [$];
	int                  n_insert;
	int                  n_lookup;
	int                  n_settings;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	ring_ordered_neighbor_table_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	ront_checker chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.fail_count (fail_count),
		.pending    (pending)
	);

	task automatic send_item(logic op, logic [FIELD_W-1:0] key, logic [FIELD_W-1:0] now);
		int gap;
		gap = $urandom_range(0, tx_gap_max);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {now, key};
		s_tuser  <= op;
		do @(posedge clk); while (!s_tready);
		if (op == OP_INSERT) begin
			n_insert++;
			recent_keys.push_back(key);
			if (recent_keys.size() > 24)
				void'(recent_keys.pop_front());
		end else begin
			n_lookup++;
		end
	endtask

	task automatic drain;
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	task automatic write_own_id(logic [FIELD_W-1:0] v);
		cfg_wdata <= v;
		cfg_we    <= 1'b1;
		@(posedge clk);
		cfg_we    <= 1'b0;
		@(posedge clk);
		node_id = v;
		n_settings++;
	endtask

	function automatic logic [FIELD_W-1:0] pick_key();
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 40 && recent_keys.size() != 0)
			return recent_keys[$urandom_range(0, recent_keys.size() - 1)];
		if (sel < 48)
			return node_id;
		if (sel < 56) begin
			case ($urandom_range(0, 3))
				0:       return node_id + 1;
				1:       return node_id - 1;
				2:       return '0;
				default: return '1;
			endcase
		end
		// keys bunched around the ring start stress wraparound ordering
		if (sel < 70)
			return node_id + FIELD_W'($urandom_range(0, 64)) - FIELD_W'(32);
		return $urandom();
	endfunction

	function automatic logic [FIELD_W-1:0] pick_now();
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 15)
			return $urandom();
		if (sel < 25)
			return tick & ~FIELD_W'(15);   // repeated stamps make LRU ties
		return tick;
	endfunction

	task automatic random_phase(int n_items);
		int i;
		for (i = 0; i < n_items; i++) begin
			tick = tick + FIELD_W'($urandom_range(0, 3));
			if (i == 40)
				long_hold = 1'b1;
			send_item(($urandom_range(0, 99) < 60) ? OP_INSERT : OP_LOOKUP,
				pick_key(), pick_now());
		end
		drain();
	endtask

	// receiver side: per-result stall, plus one long hold-off on request
	initial begin
		int stall;
		m_tready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (long_hold) begin
				m_tready <= 1'b0;
				repeat (250) @(posedge clk);
				long_hold = 1'b0;
			end
			stall = $urandom_range(0, rx_stall_max);
			if (stall != 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	initial begin
		int k;
		arst_n       = 1'b0;
		cfg_we       = 1'b0;
		cfg_wdata    = '0;
		s_tvalid     = 1'b0;
		s_tdata      = '0;
		s_tuser      = OP_INSERT;
		tx_gap_max   = 11;
		rx_stall_max = 11;
		long_hold    = 1'b0;
		node_id      = '0;
		tick         = 32'h100;
		n_insert     = 0;
		n_lookup     = 0;
		n_settings   = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty table, own id, extremes, refresh, fill and evict
		write_own_id(32'h8000_0000);
		send_item(OP_LOOKUP, 32'h0000_0000, 32'h0);
		send_item(OP_INSERT, 32'h8000_0000, 32'h1);
		send_item(OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_item(OP_INSERT, 32'h0000_0000, 32'h0);
		send_item(OP_INSERT, 32'h8000_0001, 32'h5);
		send_item(OP_INSERT, 32'h0000_0000, 32'h7);
		send_item(OP_LOOKUP, 32'h8000_0000, 32'h0);
		send_item(OP_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_item(OP_LOOKUP, 32'h7FFF_FFFF, 32'h0);
		for (k = 0; k < 13; k++)
			send_item(OP_INSERT, 32'h9000_0000 + k * 32'h0500_0000, 32'h10);
		send_item(OP_INSERT, 32'h0000_1000, 32'h20);
		send_item(OP_INSERT, 32'h4000_0000, 32'h0);
		send_item(OP_LOOKUP, 32'h0000_0800, 32'h0);
		drain();

		// own id changes keep the held entries in their old order
		random_phase(170);
		write_own_id(32'h0000_0000);
		tx_gap_max   = 0;
		rx_stall_max = 0;
		random_phase(170);
		write_own_id(32'hFFFF_FFFF);
		tx_gap_max   = 11;
		rx_stall_max = 11;
		random_phase(170);
		write_own_id($urandom());
		tx_gap_max   = 3;
		random_phase(170);

		repeat (100) @(posedge clk);
		$display("covered %0d inserts and %0d lookups over %0d own-id settings,",
			n_insert, n_lookup, n_settings);
		$display("with LRU eviction on a full table, back-pressure and idle-free stretches");
		if (fail_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	initial begin
		#40_000_000;
		$display("FAIL");
		$finish;
	end

endmodule

[sim.f]
rtl/core/ront_pkg.sv
rtl/core/ront_ram.sv
rtl/core/ront_ctrl.sv
rtl/core/ront_dpath.sv
rtl/core/ring_ordered_neighbor_table_core.sv
verif/ront_checker.sv
verif/tb.sv
